// File: rtl/rolling_key_xor_byte_cipher_unit_macros.svh
// ----------------------------------------------------------------------------
// Rolling-key XOR byte cipher assertion macros
// Clocked property helpers shared by the checking code of the cipher unit.
// ----------------------------------------------------------------------------
`ifndef ROLLING_KEY_XOR_BYTE_CIPHER_UNIT_MACROS_SVH
`define ROLLING_KEY_XOR_BYTE_CIPHER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled in reset
`define RKXB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rkxb assertion failed");

// Next-cycle implication, disabled in reset
`define RKXB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rkxb assertion failed");

`else

`define RKXB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define RKXB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/rkxb_pkg.sv
// ----------------------------------------------------------------------------
// Rolling-key XOR byte cipher package
// Shared constants, register indexes and control types.
// ----------------------------------------------------------------------------
package rkxb_pkg;

    localparam int KEY_BYTES_DEFAULT = 16;
    localparam int KEY_REG_W         = 64;
    localparam int KEY_W             = 2 * KEY_REG_W;
    localparam int BYTE_W            = 8;
    localparam int CFG_IDX_W         = 1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic advance;
        logic first;
    } key_ctrl_t;

endpackage

// File: rtl/rkxb_if.sv
// ----------------------------------------------------------------------------
// Rolling-key XOR byte cipher channels
// Valid/ready interfaces for the input byte stream and the result stream.
// ----------------------------------------------------------------------------
interface rkxb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;
    logic       first;

    modport source (output valid, output data_in, output first, input ready);
    modport sink   (input valid, input data_in, input first, output ready);
endinterface

interface rkxb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

// File: rtl/rkxb_key_state.sv
// ----------------------------------------------------------------------------
// Rolling-key working key state
// Holds the working key rotated so the current position sits at entry zero,
// forms the keystream byte and advances the key by one byte per transaction.
// ----------------------------------------------------------------------------
module rkxb_key_state
    import rkxb_pkg::*;
#(
    parameter int KEY_BYTES = KEY_BYTES_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  key_ctrl_t        ctrl,
    input  logic [KEY_W-1:0] key,
    output byte_t            keystream
);

    localparam int POS_W  = $clog2(KEY_BYTES);
    localparam int PROD_W = BYTE_W + POS_W;

    byte_t            rot_reg  [KEY_BYTES];
    byte_t            rot_next [KEY_BYTES];
    byte_t            rot_cur  [KEY_BYTES];
    byte_t            byte0_reg;
    byte_t            byte0_next;
    byte_t            byte0_cur;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] pos_cur;
    logic [PROD_W-1:0] prod;
    byte_t            sum;
    byte_t            upd;

    always_comb
    begin
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            rot_cur[i] = ctrl.first ? key[BYTE_W*i +: BYTE_W] : rot_reg[i];
        end
        byte0_cur = ctrl.first ? key[BYTE_W-1:0] : byte0_reg;
        pos_cur   = ctrl.first ? '0 : pos_reg;
    end

    assign prod      = {{POS_W{1'b0}}, byte0_cur} * {{BYTE_W{1'b0}}, pos_cur};
    assign keystream = rot_cur[0] ^ prod[BYTE_W-1:0];
    assign sum       = rot_cur[0] + rot_cur[1];
    assign upd       = (sum == '0) ? byte_t'(1) : sum;

    always_comb
    begin
        for (int i = 0; i < KEY_BYTES - 1; i++)
        begin
            rot_next[i] = rot_cur[i+1];
        end
        rot_next[KEY_BYTES-1] = upd;
        byte0_next = (pos_cur == '0) ? upd : byte0_cur;
        pos_next   = (pos_cur == POS_W'(KEY_BYTES - 1)) ? '0 : pos_cur + POS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_BYTES; i++)
            begin
                rot_reg[i] <= '0;
            end
            byte0_reg <= '0;
            pos_reg   <= '0;
        end
        else if (ctrl.advance)
        begin
            rot_reg   <= rot_next;
            byte0_reg <= byte0_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

// File: rtl/rolling_key_xor_byte_cipher_unit.sv
// Result valid is registered: it rises in the cycle after an input transaction.
// Throughput: one byte per clock while results are drained; the working key
// rotates and updates one byte in the same cycle the input is taken, and the
// result register frees on the same edge it is drained.
// Reset clears the key registers, working key, position and result valid.
// ----------------------------------------------------------------------------
// Rolling-key XOR byte cipher unit
// Configuration port, input handshake, working key state and result register.
// ----------------------------------------------------------------------------
`include "rolling_key_xor_byte_cipher_unit_macros.svh"

module rolling_key_xor_byte_cipher_unit
    import rkxb_pkg::*;
#(
    parameter int KEY_BYTES = KEY_BYTES_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    rkxb_in_if.sink              in_ch,
    rkxb_out_if.source           out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_REG_W-1:0] cfg_wdata
);

    logic [KEY_REG_W-1:0] key_low_reg;
    logic [KEY_REG_W-1:0] key_high_reg;
    logic                 out_valid_reg;
    byte_t                data_out_reg;
    logic                 in_accept;
    key_ctrl_t            key_ctrl;
    byte_t                keystream;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                REG_KEY_HIGH: key_high_reg <= cfg_wdata;
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;

    assign key_ctrl.advance = in_accept;
    assign key_ctrl.first   = in_ch.first;

    rkxb_key_state #(
        .KEY_BYTES (KEY_BYTES)
    ) u_key_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (key_ctrl),
        .key       ({key_high_reg, key_low_reg}),
        .keystream (keystream)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            data_out_reg <= in_ch.data_in ^ keystream;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.data_out = data_out_reg;

    `RKXB_ASSERT_NXT(a_accept_gives_result, clk, rst_n, in_accept, out_ch.valid)
    `RKXB_ASSERT_IMP(a_stall_blocks_input, clk, rst_n, out_ch.valid && !out_ch.ready, !in_ch.ready)
    `RKXB_ASSERT_NXT(a_drain_clears_valid, clk, rst_n, out_ch.valid && out_ch.ready && !in_accept, !out_ch.valid)

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Rolling-key XOR byte cipher unit testbench
// Drives byte transactions through the input channel under random idling and
// stalls, predicts each output byte from a local copy of the key registers and
// working key, and compares every result transaction against it in order.
// ----------------------------------------------------------------------------
module testbench;
    import rkxb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 50;
    localparam int RX_HOLD     = 300;

    typedef struct {
        byte_t data;
        logic  first;
    } cipher_in_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [KEY_REG_W-1:0] cfg_wdata;

    rkxb_in_if  in_ch();
    rkxb_out_if out_ch();

    rolling_key_xor_byte_cipher_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    cipher_in_t pending_bytes[$];
    byte_t      expected_out[$];
    cipher_in_t next_item;

    logic [KEY_REG_W-1:0] key_lo_copy;
    logic [KEY_REG_W-1:0] key_hi_copy;
    byte_t                working_key[16];
    logic [3:0]           key_pos;

    int  mismatches;
    int  cycle_count;
    int  tx_gap;
    int  rx_gap;
    int  rx_hold_left;
    logic rx_hold_start;
    bit  idle_on;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 30);
    endfunction

    function automatic byte_t cipher_byte(byte_t din, logic start);
        int unsigned p;
        int unsigned n;
        byte_t ks;
        byte_t sum;
        if (start)
        begin
            for (int i = 0; i < 16; i++)
                working_key[i] = (i < 8) ? key_lo_copy[8*i +: 8] : key_hi_copy[8*(i-8) +: 8];
            key_pos = '0;
        end
        p  = 32'(key_pos);
        ks = working_key[p] ^ byte_t'(int'(working_key[0]) * p);
        n  = (p < KEY_BYTES_DEFAULT - 1) ? p + 1 : 0;
        sum = working_key[p] + working_key[n];
        if (sum == 8'h00)
            sum = 8'h01;
        working_key[p] = sum;
        key_pos = (p + 1 >= KEY_BYTES_DEFAULT) ? 4'd0 : 4'(p + 1);
        return din ^ ks;
    endfunction

    function automatic logic [KEY_REG_W-1:0] pick_key(int sel);
        case (sel % 5)
            0: return '0;
            1: return '1;
            2: return {8{8'h80}};
            3: return {8{8'h01}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic note_mismatch(string what, byte_t exp_val, byte_t act_val);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): expected 0x%02h, actual 0x%02h at cycle %0d",
                     what, exp_val, act_val, cycle_count);
    endtask

    task automatic queue_byte(byte_t d, logic f);
        cipher_in_t it;
        it.data  = d;
        it.first = f;
        pending_bytes.push_back(it);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_ch.valid || expected_out.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_key(logic [KEY_REG_W-1:0] lo, logic [KEY_REG_W-1:0] hi);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_KEY_LOW;
        cfg_wdata <= lo;
        @(posedge clk);
        cfg_index <= REG_KEY_HIGH;
        cfg_wdata <= hi;
        @(posedge clk);
        cfg_we    <= 1'b0;
        key_lo_copy = lo;
        key_hi_copy = hi;
        @(negedge clk);
    endtask

    task automatic queue_phase(int n, bit open_msg, int msg_rate);
        for (int k = 0; k < n; k++)
            queue_byte(byte_t'($urandom), (k == 0 && open_msg) || $urandom_range(0, msg_rate) == 0);
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_KEY_LOW;
        cfg_wdata      = '0;
        in_ch.valid    = 1'b0;
        in_ch.data_in  = '0;
        in_ch.first    = 1'b0;
        out_ch.ready   = 1'b0;
        rx_hold_start  = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[rolling_key_xor_byte_cipher_unit] ERROR");
            $finish;
        end
    end

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid   <= 1'b0;
            in_ch.data_in <= '0;
            in_ch.first   <= 1'b0;
            tx_gap = 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid)
                expected_out.push_back(cipher_byte(in_ch.data_in, in_ch.first));
            if (tx_gap != 0)
            begin
                tx_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_bytes.size() != 0)
            begin
                next_item = pending_bytes.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.data_in <= next_item.data;
                in_ch.first   <= next_item.first;
                tx_gap = idle_on ? pick_gap() : 0;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // receiver long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rx_hold_left <= 0;
        else if (rx_hold_start)
            rx_hold_left <= RX_HOLD;
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_out.size() == 0)
                    note_mismatch("no transaction pending", 8'h00, out_ch.data_out);
                else if (expected_out[0] !== out_ch.data_out)
                    note_mismatch("data_out", expected_out.pop_front(), out_ch.data_out);
                else
                    void'(expected_out.pop_front());
                rx_gap = idle_on ? pick_gap() : 0;
            end
            if (rx_hold_left != 0 || rx_hold_start)
                out_ch.ready <= 1'b0;
            else if (rx_gap != 0)
            begin
                rx_gap--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        mismatches  = 0;
        cycle_count = 0;
        idle_on     = 1'b1;
        key_lo_copy = '0;
        key_hi_copy = '0;
        key_pos     = '0;
        for (int i = 0; i < 16; i++)
            working_key[i] = 8'h00;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // no message start since reset
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h5A, 1'b0);
        wait_drained();

        // full message wrapping the position, zero sums forced to one
        write_key({8{8'h80}}, '1);
        queue_byte(8'h00, 1'b1);
        for (int k = 0; k < 17; k++)
            queue_byte((k % 2) ? 8'h00 : 8'hFF, 1'b0);
        wait_drained();

        // key written mid-message takes effect at the next start
        write_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
        queue_byte(8'hA5, 1'b0);
        queue_byte(8'h3C, 1'b0);
        queue_byte(8'hC3, 1'b1);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_key(pick_key(ph), pick_key(ph + 1 + $urandom_range(0, 3)));
            idle_on = ($urandom_range(0, 3) != 0);
            if (ph == 1)
            begin
                idle_on = 1'b0;
                @(posedge clk);
                rx_hold_start <= 1'b1;
                @(posedge clk);
                rx_hold_start <= 1'b0;
                @(negedge clk);
            end
            case ($urandom_range(0, 2))
                0: queue_phase(PHASE_ITEMS, ph % 3 != 2, 3);
                1: queue_phase(PHASE_ITEMS, ph % 3 != 2, 15);
                default: queue_phase(PHASE_ITEMS, ph % 3 != 2, 40);
            endcase
            wait_drained();
        end

        repeat (10) @(negedge clk);
        if (mismatches == 0 && expected_out.size() == 0)
            $display("[rolling_key_xor_byte_cipher_unit] OK");
        else
            $display("[rolling_key_xor_byte_cipher_unit] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rkxb_pkg.sv
rtl/rkxb_if.sv
rtl/rkxb_key_state.sv
rtl/rolling_key_xor_byte_cipher_unit.sv
tb/sv/testbench.sv
